// ===== sv/ang_pkg.sv =====
package ang_pkg;

    localparam int CHANNELS  = 2;
    localparam int CH_ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CFG_IDX_W = 2;

    localparam int MUL_A_W = 28;
    localparam int MUL_B_W = 18;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK    = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD      = CFG_IDX_W'(3);

    localparam logic [15:0] THRESHOLD_RESET = 16'd328;
    localparam logic [15:0] ATTACK_RESET    = 16'd6554;
    localparam logic [15:0] RELEASE_RESET   = 16'd655;
    localparam logic [15:0] HOLD_RESET      = 16'd4800;

    localparam logic [16:0] UNITY         = 17'd32768;
    localparam logic [16:0] GAIN_CLOSED   = 17'd1638;
    localparam logic [16:0] GAIN_FLOOR    = 17'd655;
    localparam logic [16:0] IMPULSE_LEVEL = 17'd8231;

    localparam logic signed [MUL_B_W-1:0] NOISE_COEFF = MUL_B_W'(655);
    localparam logic signed [MUL_B_W-1:0] TENTH_Q15   = MUL_B_W'(3277);
    localparam logic signed [MUL_B_W-1:0] DIV5_RECIP  = MUL_B_W'(104858);
    localparam int                        DIV5_SHIFT  = 19;

    localparam logic signed [PROD_W-1:0] RND15 = PROD_W'(1) <<< 14;
    localparam logic signed [PROD_W-1:0] RND16 = PROD_W'(1) <<< 15;
    localparam logic signed [PROD_W-1:0] RND30 = PROD_W'(1) <<< 29;

    typedef struct packed {
        logic               channel;
        logic signed [15:0] sample_in;
    } sample_word_t;

    typedef struct packed {
        logic signed [15:0] sample_out;
        logic               gate_open;
    } result_word_t;

    typedef struct packed {
        logic [15:0] level_envelope;
        logic [15:0] noise_level;
        logic [15:0] hold_left;
        logic        open_flag;
        logic [15:0] gate_gain;
    } chan_state_t;

    localparam int STATE_W = $bits(chan_state_t);

    localparam chan_state_t STATE_RESET = '{
        level_envelope: 16'd0,
        noise_level:    16'd0,
        hold_left:      16'd0,
        open_flag:      1'b0,
        gate_gain:      16'd32768
    };

    typedef struct packed {
        logic signed [MUL_A_W-1:0] a;
        logic signed [MUL_B_W-1:0] b;
    } mul_req_t;

endpackage

// ===== sv/adaptive_noise_gate.sv =====
// Channel  | Signals                                 | Word
// ---------+-----------------------------------------+-------------------------------
// sample   | sample_valid, sample_ready, sample_word | channel, sample_in
// result   | result_valid, result_ready, result_word | sample_out, gate_open
// cfg      | cfg_valid, cfg_ready, cfg_index, cfg_data | register index, 16-bit value
//
// One sample word passes through LOAD, ENV, NMUL, NOISE, THR1, THR2, DECIDE, GMUL,
// GAIN, OMUL and DONE before its result is loaded into the output register; no new
// word is taken while one is in progress, only once the block is back in IDLE. The
// registered state memory read and seven multiplies through the one shared registered multiplier set the pace.
// A finished result waits in the output register, so the next sample is taken
// while the previous result is still stalled; a second finished result holds
// until the output register frees. Reset needs no clearing pass: per-channel
// valid bits make unwritten channels read as their reset state.
module adaptive_noise_gate (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              sample_valid,
    output logic                              sample_ready,
    input  ang_pkg::sample_word_t             sample_word,
    output logic                              result_valid,
    input  logic                              result_ready,
    output ang_pkg::result_word_t             result_word,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ang_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [15:0]                       cfg_data
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_LOAD   = 4'd1;
    localparam logic [3:0] S_ENV    = 4'd2;
    localparam logic [3:0] S_NMUL   = 4'd3;
    localparam logic [3:0] S_NOISE  = 4'd4;
    localparam logic [3:0] S_THR1   = 4'd5;
    localparam logic [3:0] S_THR2   = 4'd6;
    localparam logic [3:0] S_DECIDE = 4'd7;
    localparam logic [3:0] S_GMUL   = 4'd8;
    localparam logic [3:0] S_GAIN   = 4'd9;
    localparam logic [3:0] S_OMUL   = 4'd10;
    localparam logic [3:0] S_DONE   = 4'd11;

    logic [3:0] state_reg, state_next;

    logic [15:0] threshold_reg, threshold_next;
    logic [15:0] attack_reg, attack_next;
    logic [15:0] release_reg, release_next;
    logic [15:0] hold_cfg_reg, hold_cfg_next;

    logic [ang_pkg::CHANNELS-1:0] valid_reg, valid_next;
    logic                         out_valid_reg, out_valid_next;

    ang_pkg::result_word_t             out_word_reg, out_word_next;
    logic [ang_pkg::CH_ADDR_W-1:0]     addr_reg, addr_next;
    logic                              chan_ok_reg, chan_ok_next;
    logic signed [15:0]                x_reg, x_next;
    logic [16:0]                       env_reg, env_next;
    logic [16:0]                       noise_reg, noise_next;
    logic [15:0]                       hold_reg, hold_next;
    logic                              open_reg, open_next;
    logic [16:0]                       gain_reg, gain_next;
    logic [15:0]                       smooth_reg, smooth_next;

    ang_pkg::mul_req_t                 mul_req;
    logic signed [ang_pkg::PROD_W-1:0] prod;

    logic                              ram_we;
    logic                              ram_re;
    logic [ang_pkg::STATE_W-1:0]       ram_rdata;
    ang_pkg::chan_state_t              wr_state;
    ang_pkg::chan_state_t              cur_state;

    logic signed [16:0] x_ext;
    logic [16:0]        ax;
    logic signed [19:0] rnd15;
    logic signed [19:0] rnd16;
    logic signed [19:0] rnd30;
    logic signed [19:0] acc;
    logic signed [17:0] diff;
    logic [16:0]        rel_plus;
    logic [17:0]        thr;
    logic               impulse;
    logic signed [15:0] y;

    ang_ram #(
        .WIDTH (ang_pkg::STATE_W),
        .DEPTH (ang_pkg::CHANNELS)
    ) u_state_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (addr_reg),
        .wdata (wr_state),
        .re    (ram_re),
        .raddr (ang_pkg::CH_ADDR_W'(sample_word.channel)),
        .rdata (ram_rdata)
    );

    ang_mul u_mul (
        .clk  (clk),
        .req  (mul_req),
        .prod (prod)
    );

    assign sample_ready = (state_reg == S_IDLE);
    assign cfg_ready    = 1'b1;
    assign result_valid = out_valid_reg;
    assign result_word  = out_word_reg;

    always_comb
    begin
        cur_state = valid_reg[addr_reg] ? ang_pkg::chan_state_t'(ram_rdata)
                                        : ang_pkg::STATE_RESET;
        wr_state = '{
            level_envelope: env_reg[15:0],
            noise_level:    noise_reg[15:0],
            hold_left:      hold_reg,
            open_flag:      open_reg,
            gate_gain:      gain_reg[15:0]
        };
        x_ext    = 17'(x_reg);
        ax       = x_reg[15] ? 17'(-x_ext) : 17'(x_ext);
        rnd15    = 20'((prod + ang_pkg::RND15) >>> 15);
        rnd16    = 20'((prod + ang_pkg::RND16) >>> 16);
        rnd30    = 20'((prod + ang_pkg::RND30) >>> 30);
        rel_plus = 17'(release_reg) + 17'd2;
        thr      = 18'(threshold_reg) + 18'(rnd30[16:0]);
        impulse  = (env_reg > ang_pkg::IMPULSE_LEVEL)
                && (21'(env_reg) > {thr[17:0], 3'b000})
                && (21'(env_reg) > ((21'(noise_reg) << 3) + (21'(noise_reg) << 1)));
        if (rnd15 > 20'sd32767)
        begin
            y = 16'sh7FFF;
        end
        else if (rnd15 < -20'sd32768)
        begin
            y = -16'sh8000;
        end
        else
        begin
            y = 16'(rnd15);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        threshold_next = threshold_reg;
        attack_next    = attack_reg;
        release_next   = release_reg;
        hold_cfg_next  = hold_cfg_reg;
        valid_next     = valid_reg;
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        addr_next      = addr_reg;
        chan_ok_next   = chan_ok_reg;
        x_next         = x_reg;
        env_next       = env_reg;
        noise_next     = noise_reg;
        hold_next      = hold_reg;
        open_next      = open_reg;
        gain_next      = gain_reg;
        smooth_next    = smooth_reg;
        mul_req        = '0;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        diff           = '0;
        acc            = '0;

        if (cfg_valid)
        begin
            case (cfg_index)
                ang_pkg::CFG_THRESHOLD: threshold_next = cfg_data;
                ang_pkg::CFG_ATTACK:    attack_next    = cfg_data;
                ang_pkg::CFG_RELEASE:   release_next   = cfg_data;
                ang_pkg::CFG_HOLD:      hold_cfg_next  = cfg_data;
                default: ;
            endcase
        end

        if (out_valid_reg && result_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (sample_valid)
                begin
                    x_next       = sample_word.sample_in;
                    addr_next    = ang_pkg::CH_ADDR_W'(sample_word.channel);
                    chan_ok_next = (32'(sample_word.channel) < ang_pkg::CHANNELS);
                    if (32'(sample_word.channel) < ang_pkg::CHANNELS)
                    begin
                        ram_re     = 1'b1;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_LOAD:
            begin
                env_next   = {1'b0, cur_state.level_envelope};
                noise_next = {1'b0, cur_state.noise_level};
                hold_next  = cur_state.hold_left;
                open_next  = cur_state.open_flag;
                gain_next  = {1'b0, cur_state.gate_gain};
                diff       = $signed({1'b0, ax}) - $signed({2'b00, cur_state.level_envelope});
                mul_req.a  = ang_pkg::MUL_A_W'(diff);
                mul_req.b  = (ax > {1'b0, cur_state.level_envelope})
                           ? $signed({2'b00, attack_reg}) : $signed({2'b00, release_reg});
                state_next = S_ENV;
            end
            S_ENV:
            begin
                acc = $signed({3'b000, env_reg}) + rnd16;
                if (acc < 20'sd0)
                begin
                    env_next = 17'd0;
                end
                else if (acc > 20'sd32768)
                begin
                    env_next = ang_pkg::UNITY;
                end
                else
                begin
                    env_next = 17'(acc);
                end
                mul_req.a  = $signed(ang_pkg::MUL_A_W'(rel_plus));
                mul_req.b  = ang_pkg::DIV5_RECIP;
                state_next = S_NMUL;
            end
            S_NMUL:
            begin
                smooth_next = 16'(prod >>> ang_pkg::DIV5_SHIFT);
                diff        = $signed({1'b0, env_reg}) - $signed({1'b0, noise_reg});
                mul_req.a   = ang_pkg::MUL_A_W'(diff);
                mul_req.b   = ang_pkg::NOISE_COEFF;
                state_next  = S_NOISE;
            end
            S_NOISE:
            begin
                acc = $signed({3'b000, noise_reg}) + rnd16;
                if (acc < 20'sd0)
                begin
                    noise_next = 17'd0;
                end
                else if (acc > 20'sd32768)
                begin
                    noise_next = ang_pkg::UNITY;
                end
                else
                begin
                    noise_next = 17'(acc);
                end
                state_next = S_THR1;
            end
            S_THR1:
            begin
                mul_req.a  = $signed(ang_pkg::MUL_A_W'(noise_reg));
                mul_req.b  = ang_pkg::TENTH_Q15;
                state_next = S_THR2;
            end
            S_THR2:
            begin
                mul_req.a  = $signed({1'b0, prod[ang_pkg::MUL_A_W-2:0]});
                mul_req.b  = $signed({2'b00, threshold_reg});
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (impulse)
                begin
                    open_next = 1'b0;
                    hold_next = 16'd0;
                    gain_next = ang_pkg::GAIN_CLOSED;
                end
                else if (18'(env_reg) > thr)
                begin
                    open_next = 1'b1;
                    hold_next = hold_cfg_reg;
                end
                else if (hold_reg != 16'd0)
                begin
                    hold_next = hold_reg - 16'd1;
                    if (hold_reg == 16'd1)
                    begin
                        open_next = 1'b0;
                    end
                end
                else
                begin
                    open_next = 1'b0;
                end
                state_next = S_GMUL;
            end
            S_GMUL:
            begin
                if (open_reg)
                begin
                    diff      = $signed({1'b0, ang_pkg::UNITY}) - $signed({1'b0, gain_reg});
                    mul_req.b = $signed({2'b00, attack_reg});
                end
                else
                begin
                    diff      = $signed({1'b0, ang_pkg::GAIN_CLOSED}) - $signed({1'b0, gain_reg});
                    mul_req.b = $signed({2'b00, smooth_reg});
                end
                mul_req.a  = ang_pkg::MUL_A_W'(diff);
                state_next = S_GAIN;
            end
            S_GAIN:
            begin
                acc = $signed({3'b000, gain_reg}) + rnd16;
                if (acc < $signed({3'b000, ang_pkg::GAIN_FLOOR}))
                begin
                    gain_next = ang_pkg::GAIN_FLOOR;
                end
                else if (acc > $signed({3'b000, ang_pkg::UNITY}))
                begin
                    gain_next = ang_pkg::UNITY;
                end
                else
                begin
                    gain_next = 17'(acc);
                end
                state_next = S_OMUL;
            end
            S_OMUL:
            begin
                mul_req.a  = ang_pkg::MUL_A_W'(x_reg);
                mul_req.b  = $signed({1'b0, gain_reg});
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // hold the output product while the word waits
                mul_req.a = ang_pkg::MUL_A_W'(x_reg);
                mul_req.b = $signed({1'b0, gain_reg});
                ram_we = chan_ok_reg;
                if (chan_ok_reg)
                begin
                    valid_next[addr_reg] = 1'b1;
                end
                if (!out_valid_reg || result_ready)
                begin
                    out_valid_next = 1'b1;
                    if (chan_ok_reg)
                    begin
                        out_word_next.sample_out = y;
                        out_word_next.gate_open  = open_reg;
                    end
                    else
                    begin
                        out_word_next.sample_out = 16'sd0;
                        out_word_next.gate_open  = 1'b0;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            threshold_reg <= ang_pkg::THRESHOLD_RESET;
            attack_reg    <= ang_pkg::ATTACK_RESET;
            release_reg   <= ang_pkg::RELEASE_RESET;
            hold_cfg_reg  <= ang_pkg::HOLD_RESET;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            threshold_reg <= threshold_next;
            attack_reg    <= attack_next;
            release_reg   <= release_next;
            hold_cfg_reg  <= hold_cfg_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg <= out_word_next;
        addr_reg     <= addr_next;
        chan_ok_reg  <= chan_ok_next;
        x_reg        <= x_next;
        env_reg      <= env_next;
        noise_reg    <= noise_next;
        hold_reg     <= hold_next;
        open_reg     <= open_next;
        gain_reg     <= gain_next;
        smooth_reg   <= smooth_next;
    end

endmodule

// ===== sv/ang_ram.sv =====
module ang_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic                                       re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/ang_mul.sv =====
module ang_mul (
    input  logic                                  clk,
    input  ang_pkg::mul_req_t                     req,
    output logic signed [ang_pkg::PROD_W-1:0]     prod
);

    logic signed [ang_pkg::PROD_W-1:0] prod_reg;
    logic signed [ang_pkg::PROD_W-1:0] prod_next;

    always_comb
    begin
        prod_next = req.a * req.b;
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

// ===== sv/ang_checker.sv =====
module ang_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          sample_valid,
    input logic                          sample_ready,
    input ang_pkg::sample_word_t         sample_word,
    input logic                          result_valid,
    input logic                          result_ready,
    input ang_pkg::result_word_t         result_word,
    input logic                          cfg_valid,
    input logic                          cfg_ready,
    input logic [ang_pkg::CFG_IDX_W-1:0] cfg_index,
    input logic [15:0]                   cfg_data
);

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_word))
        else $error("result word dropped or changed while stalled");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && sample_ready |=> !sample_ready)
        else $error("sample taken while previous word still in flight");

    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && sample_ready |=> !$rose(result_valid))
        else $error("result appeared in the cycle after acceptance");

    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !result_valid)
        else $error("result valid right out of reset");

endmodule

bind adaptive_noise_gate ang_checker u_ang_checker (.*);

// ===== dv/noise_gate_checker.sv =====
`timescale 1ns / 1ps

module noise_gate_checker
    import ang_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  sample_valid,
    input  logic                  sample_ready,
    input  sample_word_t          sample_word,
    input  logic                  result_valid,
    input  logic                  result_ready,
    input  result_word_t          result_word,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [15:0]           cfg_data,
    output int                    mismatches,
    output int                    awaiting
);

    localparam longint FULL_GAIN   = UNITY;
    localparam longint SHUT_GAIN   = GAIN_CLOSED;
    localparam longint MIN_GAIN    = GAIN_FLOOR;
    localparam longint IMPULSE_ENV = IMPULSE_LEVEL;
    localparam longint NOISE_RATE  = 655;
    localparam longint TENTH       = 3277;
    localparam int     EXP_DEPTH   = 64;

    logic [15:0]  base_threshold;
    logic [15:0]  attack_rate;
    logic [15:0]  release_rate;
    logic [15:0]  hold_length;
    chan_state_t  chan_st [CHANNELS];
    result_word_t gated_q [EXP_DEPTH];
    int           wr_count;
    int           rd_count;

    function automatic longint round_down_shift(input longint p, input int sh);
        return (p + (longint'(1) <<< (sh - 1))) >>> sh;
    endfunction

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // advance one channel by one sample and return the gated word
    function automatic result_word_t apply_gate(input sample_word_t w);
        chan_state_t  st;
        result_word_t r;
        longint       x, ax, env, noise, thr, gain, hold, smooth;
        longint       thr_base, atk, rel;
        logic         opened;
        logic         impulse;
        st       = chan_st[w.channel];
        thr_base = base_threshold;
        atk      = attack_rate;
        rel      = release_rate;
        x        = longint'(signed'(w.sample_in));
        ax       = (x < 0) ? -x : x;

        env = st.level_envelope;
        env += round_down_shift(((ax > env) ? atk : rel) * (ax - env), 16);
        env = clip(env, 0, FULL_GAIN);

        noise = st.noise_level;
        noise += round_down_shift(NOISE_RATE * (env - noise), 16);
        noise = clip(noise, 0, FULL_GAIN);

        thr = thr_base + round_down_shift(thr_base * noise * TENTH, 30);
        impulse = (env > IMPULSE_ENV) && (env > 8 * thr) && (env > 10 * noise);

        opened = st.open_flag;
        hold   = st.hold_left;
        gain   = st.gate_gain;

        if (impulse)
        begin
            opened = 1'b0;
            hold   = 0;
            gain   = SHUT_GAIN;
        end
        else if (env > thr)
        begin
            opened = 1'b1;
            hold   = hold_length;
        end
        else if (hold > 0)
        begin
            hold--;
            if (hold == 0)
                opened = 1'b0;
        end
        else
        begin
            opened = 1'b0;
        end

        if (opened)
        begin
            gain += round_down_shift(atk * (FULL_GAIN - gain), 16);
        end
        else
        begin
            smooth = (rel + 2) / 5;
            gain += round_down_shift(smooth * (SHUT_GAIN - gain), 16);
        end
        gain = clip(gain, MIN_GAIN, FULL_GAIN);

        st.level_envelope = env[15:0];
        st.noise_level    = noise[15:0];
        st.hold_left      = hold[15:0];
        st.open_flag      = opened;
        st.gate_gain      = gain[15:0];
        chan_st[w.channel] = st;

        r.sample_out = 16'(clip(round_down_shift(x * gain, 15), -32768, 32767));
        r.gate_open  = opened;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_word_t want;
        if (!rst_n)
        begin
            base_threshold = THRESHOLD_RESET;
            attack_rate    = ATTACK_RESET;
            release_rate   = RELEASE_RESET;
            hold_length    = HOLD_RESET;
            foreach (chan_st[i])
                chan_st[i] = STATE_RESET;
            wr_count   = 0;
            rd_count   = 0;
            mismatches = 0;
            awaiting <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_THRESHOLD: base_threshold = cfg_data;
                    CFG_ATTACK:    attack_rate    = cfg_data;
                    CFG_RELEASE:   release_rate   = cfg_data;
                    CFG_HOLD:      hold_length    = cfg_data;
                    default: ;
                endcase
            end
            if (sample_valid && sample_ready)
            begin
                gated_q[wr_count % EXP_DEPTH] = apply_gate(sample_word);
                wr_count++;
            end
            if (result_valid && result_ready)
            begin
                if (wr_count == rd_count)
                begin
                    $display("%0t: unexpected word, got sample_out %0d gate_open %0b",
                             $time, result_word.sample_out, result_word.gate_open);
                    mismatches++;
                end
                else
                begin
                    want = gated_q[rd_count % EXP_DEPTH];
                    rd_count++;
                    if (result_word.sample_out !== want.sample_out)
                    begin
                        $display("%0t: sample_out expected %0d, got %0d",
                                 $time, want.sample_out, result_word.sample_out);
                        mismatches++;
                    end
                    if (result_word.gate_open !== want.gate_open)
                    begin
                        $display("%0t: gate_open expected %0b, got %0b",
                                 $time, want.gate_open, result_word.gate_open);
                        mismatches++;
                    end
                end
            end
            awaiting <= wr_count - rd_count;
        end
    end

endmodule

// ===== dv/tb_adaptive_noise_gate.sv =====
`timescale 1ns / 1ps

module tb_adaptive_noise_gate;

    import ang_pkg::*;

    typedef enum {SEG_QUIET, SEG_LOUD, SEG_MID, SEG_ANY} seg_kind_e;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 sample_valid = 1'b0;
    logic                 sample_ready;
    sample_word_t         sample_word  = '0;
    logic                 result_valid;
    logic                 result_ready = 1'b0;
    result_word_t         result_word;
    logic                 cfg_valid    = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index    = CFG_THRESHOLD;
    logic [15:0]          cfg_data     = '0;
    int                   mismatches;
    int                   awaiting;
    logic                 tx_fast      = 1'b0;
    logic                 rx_fast      = 1'b0;
    int                   rx_wait      = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    adaptive_noise_gate u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample_word  (sample_word),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_word  (result_word),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    noise_gate_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample_word  (sample_word),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_word  (result_word),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .awaiting     (awaiting)
    );

    // stall the result side for a random count after each word, unless rx_fast is set
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                rx_wait = rx_fast ? 0 : $urandom_range(0, 15);
                if (rx_wait != 0)
                    result_ready <= 1'b0;
            end
            else if (!result_ready)
            begin
                if (rx_wait > 0)
                    rx_wait--;
                if (rx_wait == 0)
                    result_ready <= 1'b1;
            end
        end
    end

    task automatic send_sample(input logic ch, input logic signed [15:0] s);
        int gap;
        gap = tx_fast ? 0 : $urandom_range(0, 15);
        if (gap != 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_valid          <= 1'b1;
        sample_word.channel   <= ch;
        sample_word.sample_in <= s;
        do @(posedge clk); while (!sample_ready);
    endtask

    task automatic wait_for_results();
        sample_valid <= 1'b0;
        do @(posedge clk); while (awaiting != 0);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic apply_settings(input logic [15:0] thr, input logic [15:0] atk,
                                  input logic [15:0] rel, input logic [15:0] hld);
        put_reg(CFG_THRESHOLD, thr);
        put_reg(CFG_ATTACK, atk);
        put_reg(CFG_RELEASE, rel);
        put_reg(CFG_HOLD, hld);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [15:0] draw_sample(input seg_kind_e kind);
        logic [15:0] mag;
        case (kind)
            SEG_QUIET: mag = 16'($urandom_range(0, 600));
            SEG_LOUD:  mag = 16'($urandom_range(16000, 32768));
            SEG_MID:   mag = 16'($urandom_range(0, 3000));
            default:   return 16'($urandom());
        endcase
        return $urandom_range(0, 1) ? -mag : mag;
    endfunction

    function automatic logic [15:0] draw_coeff();
        case ($urandom_range(0, 5))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            default: return 16'($urandom_range(300, 40000));
        endcase
    endfunction

    initial
    begin
        int          left;
        int          seg_len;
        seg_kind_e   kind;
        logic        seg_ch;
        logic [15:0] thr_val;
        logic [15:0] hold_val;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: extremes, then a loud burst that trips the impulse detector
        send_sample(1'b0, 16'sd0);
        repeat (4) send_sample(1'b0, 16'sd32767);
        send_sample(1'b0, -16'sd32768);
        send_sample(1'b0, -16'sd1);
        send_sample(1'b0, 16'sd1);
        repeat (3) send_sample(1'b1, 16'sd2000);
        repeat (4) send_sample(1'b1, 16'sd0);
        send_sample(1'b0, 16'h5555);
        send_sample(1'b1, 16'hAAAA);
        wait_for_results();

        // zero hold: gate drops on the first quiet sample
        apply_settings(16'd1000, 16'hFFFF, 16'hFFFF, 16'd0);
        send_sample(1'b0, 16'sd5000);
        send_sample(1'b0, 16'sd0);
        send_sample(1'b0, -16'sd5000);
        send_sample(1'b0, 16'sd0);
        wait_for_results();

        // threshold above unity
        apply_settings(16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF);
        send_sample(1'b1, 16'sd32767);
        send_sample(1'b1, 16'sd32767);
        send_sample(1'b1, -16'sd32768);
        wait_for_results();

        for (int p = 0; p < 10; p++)
        begin
            case ($urandom_range(0, 7))
                0:       thr_val = 16'd0;
                1:       thr_val = 16'($urandom_range(32769, 65535));
                2:       thr_val = 16'd32768;
                default: thr_val = 16'($urandom_range(0, 4000));
            endcase
            hold_val = ($urandom_range(0, 7) == 0) ? 16'($urandom())
                                                    : 16'($urandom_range(0, 40));
            apply_settings(thr_val, draw_coeff(), draw_coeff(), hold_val);
            tx_fast = ($urandom_range(0, 3) == 0);
            rx_fast = ($urandom_range(0, 3) == 0);
            left = 192;
            while (left > 0)
            begin
                kind    = seg_kind_e'($urandom_range(0, 3));
                seg_len = $urandom_range(1, 40);
                seg_ch  = 1'($urandom_range(0, 1));
                for (int k = 0; k < seg_len && left > 0; k++)
                begin
                    send_sample(($urandom_range(0, 4) == 0) ? ~seg_ch : seg_ch,
                                draw_sample(kind));
                    left--;
                end
                if ($urandom_range(0, 20) == 0)
                    wait_for_results();
            end
            wait_for_results();
        end

        repeat (40) @(posedge clk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/ang_pkg.sv
sv/ang_ram.sv
sv/ang_mul.sv
sv/adaptive_noise_gate.sv
sv/ang_checker.sv
dv/noise_gate_checker.sv
dv/tb_adaptive_noise_gate.sv
